// ===== rtl/core/tcr_pkg.sv =====
`default_nettype none

package tcr_pkg;

   typedef logic [23:0] rgb_type;

   // Kind code of a foreground or background color
   typedef enum logic [1:0] {
      KIND_DEFAULT     = 2'd0,
      KIND_INDEX       = 2'd1,
      KIND_DIRECT      = 2'd2,
      KIND_DEFAULT_ALT = 2'd3
   } kind_type;

   // Where a decoded color comes from
   typedef enum logic [2:0] {
      SRC_DEFAULT = 3'd0,
      SRC_DIRECT  = 3'd1,
      SRC_THEME   = 3'd2,
      SRC_CUBE    = 3'd3,
      SRC_GRAY    = 3'd4
   } src_type;

   typedef enum logic [1:0] {
      LINK_NONE   = 2'd0,
      LINK_INSIDE = 2'd1,
      LINK_HOVER  = 2'd2
   } link_type;

   typedef enum logic [2:0] {
      CSR_DEFAULT_FG    = 3'd0,
      CSR_DEFAULT_BG    = 3'd1,
      CSR_DARK_THEME    = 3'd2,
      CSR_SELECTION_BG  = 3'd3,
      CSR_LINK_FG       = 3'd4,
      CSR_LINK_HOVER_FG = 3'd5
   } csr_index_type;

   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 24;

   localparam logic [7:0] PaletteThemeEnd = 8'd16;
   localparam logic [7:0] PaletteCubeLast = 8'd231;
   localparam logic [7:0] PaletteGrayBase = 8'd232;

   localparam rgb_type RESET_DEFAULT_FG    = 24'hFFFFFF;
   localparam rgb_type RESET_DEFAULT_BG    = 24'h000000;
   localparam rgb_type RESET_SELECTION_BG  = 24'h333333;
   localparam rgb_type RESET_LINK_FG       = 24'h0000FF;
   localparam rgb_type RESET_LINK_HOVER_FG = 24'h00FFFF;

   localparam rgb_type DARK_TABLE [16] = '{
      24'h000000, 24'hCD0000, 24'h00CD00, 24'hCDCD00,
      24'h3B78FF, 24'hCD00CD, 24'h00CDCD, 24'hE5E5E5,
      24'h7F7F7F, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
      24'h5C5CFF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
   };

   localparam rgb_type LIGHT_TABLE [16] = '{
      24'h000000, 24'hCD0000, 24'h00A000, 24'hA07000,
      24'h0000EE, 24'hCD00CD, 24'h00A0A0, 24'h666666,
      24'h555555, 24'hFF0000, 24'h00CD00, 24'hCDCD00,
      24'h5C5CFF, 24'hFF00FF, 24'h00CDCD, 24'h444444
   };

   // One color after the decode stage
   typedef struct packed {
      src_type    src;
      logic [3:0] theme_idx;
      logic [2:0] cube_r;
      logic [2:0] cube_g;
      logic [2:0] cube_b;
      logic [4:0] gray_step;
      rgb_type    direct;
   } dec_type;

   // Cell attributes that ride along with the colors
   typedef struct packed {
      logic       glyph;
      logic       underline;
      logic       inverse;
      logic       selected;
      link_type   link;
   } attr_type;

   function automatic logic [7:0] cube_level(input logic [2:0] c);
      logic [7:0] lvl;
      if (c == 3'd0) begin
         lvl = 8'd0;
      end else begin
         lvl = 8'(8'd55 + 8'(c) * 8'd40);
      end
      return lvl;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tcr_decode.sv =====
`default_nettype none

module tcr_decode (
   input  wire                 clock,
   input  wire                 enable,
   input  wire  [1:0]          kind,
   input  wire  [7:0]          red,
   input  wire  [7:0]          green,
   input  wire  [7:0]          blue,
   output tcr_pkg::dec_type    dec
);

   tcr_pkg::dec_type dec_in;
   tcr_pkg::dec_type dec_ff;

   logic [7:0] cube_n;
   logic [2:0] r6;
   logic [7:0] rem8;
   logic [5:0] rem;
   logic [2:0] g6;
   logic [5:0] brem;
   logic [7:0] gray8;

   always_comb begin
      cube_n = red - tcr_pkg::PaletteThemeEnd;

      // split the cube offset into base-6 digits by compare chains
      priority if (cube_n >= 8'd180) r6 = 3'd5;
      else if (cube_n >= 8'd144)     r6 = 3'd4;
      else if (cube_n >= 8'd108)     r6 = 3'd3;
      else if (cube_n >= 8'd72)      r6 = 3'd2;
      else if (cube_n >= 8'd36)      r6 = 3'd1;
      else                           r6 = 3'd0;

      rem8 = cube_n - 8'(r6) * 8'd36;
      rem  = rem8[5:0];

      priority if (rem >= 6'd30) g6 = 3'd5;
      else if (rem >= 6'd24)     g6 = 3'd4;
      else if (rem >= 6'd18)     g6 = 3'd3;
      else if (rem >= 6'd12)     g6 = 3'd2;
      else if (rem >= 6'd6)      g6 = 3'd1;
      else                       g6 = 3'd0;

      brem  = rem - 6'(g6) * 6'd6;
      gray8 = red - tcr_pkg::PaletteGrayBase;

      dec_in.theme_idx = red[3:0];
      dec_in.cube_r    = r6;
      dec_in.cube_g    = g6;
      dec_in.cube_b    = brem[2:0];
      dec_in.gray_step = gray8[4:0];
      dec_in.direct    = {red, green, blue};

      unique case (tcr_pkg::kind_type'(kind))
         tcr_pkg::KIND_INDEX: begin
            priority if (red < tcr_pkg::PaletteThemeEnd) dec_in.src = tcr_pkg::SRC_THEME;
            else if (red <= tcr_pkg::PaletteCubeLast)    dec_in.src = tcr_pkg::SRC_CUBE;
            else                                         dec_in.src = tcr_pkg::SRC_GRAY;
         end
         tcr_pkg::KIND_DIRECT:      dec_in.src = tcr_pkg::SRC_DIRECT;
         tcr_pkg::KIND_DEFAULT:     dec_in.src = tcr_pkg::SRC_DEFAULT;
         tcr_pkg::KIND_DEFAULT_ALT: dec_in.src = tcr_pkg::SRC_DEFAULT;
         default:                   dec_in.src = tcr_pkg::SRC_DEFAULT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dec_ff <= dec_in;
      end
   end

   assign dec = dec_ff;

endmodule

`default_nettype wire

// ===== rtl/core/tcr_palette.sv =====
`default_nettype none

module tcr_palette (
   input  wire                 clock,
   input  wire                 enable,
   input  wire tcr_pkg::dec_type dec,
   input  wire                 dark_theme,
   input  wire tcr_pkg::rgb_type default_color,
   output tcr_pkg::rgb_type    color
);

   tcr_pkg::rgb_type color_in;
   tcr_pkg::rgb_type color_ff;
   logic [7:0]       gray;

   always_comb begin
      gray = 8'd8 + 8'(dec.gray_step) * 8'd10;
      unique case (dec.src)
         tcr_pkg::SRC_THEME: begin
            color_in = dark_theme ? tcr_pkg::DARK_TABLE[dec.theme_idx]
                                  : tcr_pkg::LIGHT_TABLE[dec.theme_idx];
         end
         tcr_pkg::SRC_CUBE: begin
            color_in = {tcr_pkg::cube_level(dec.cube_r),
                        tcr_pkg::cube_level(dec.cube_g),
                        tcr_pkg::cube_level(dec.cube_b)};
         end
         tcr_pkg::SRC_GRAY:    color_in = {gray, gray, gray};
         tcr_pkg::SRC_DIRECT:  color_in = dec.direct;
         tcr_pkg::SRC_DEFAULT: color_in = default_color;
         default:              color_in = default_color;
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         color_ff <= color_in;
      end
   end

   assign color = color_ff;

endmodule

`default_nettype wire

// ===== rtl/core/tcr_compose.sv =====
`default_nettype none

module tcr_compose (
   input  wire                 clock,
   input  wire                 enable,
   input  wire tcr_pkg::rgb_type  fg_color,
   input  wire tcr_pkg::rgb_type  bg_color,
   input  wire tcr_pkg::attr_type attr,
   input  wire tcr_pkg::rgb_type  selection_bg,
   input  wire tcr_pkg::rgb_type  link_fg,
   input  wire tcr_pkg::rgb_type  link_hover_fg,
   output tcr_pkg::rgb_type    fill_color,
   output tcr_pkg::rgb_type    text_color,
   output logic                draw_underline
);

   tcr_pkg::rgb_type fill_in;
   tcr_pkg::rgb_type fill_ff;
   tcr_pkg::rgb_type text_in;
   tcr_pkg::rgb_type text_ff;
   logic             uline_in;
   logic             uline_ff;
   tcr_pkg::rgb_type fg;
   logic             in_link;

   always_comb begin
      in_link = (attr.link != tcr_pkg::LINK_NONE);

      // a link overrides the foreground; the unused fourth code acts as hover
      priority if (!in_link)                     fg = fg_color;
      else if (attr.link == tcr_pkg::LINK_INSIDE) fg = link_fg;
      else                                        fg = link_hover_fg;

      priority if (attr.selected) begin
         fill_in = selection_bg;
         text_in = fg;
      end else if (attr.glyph && attr.inverse) begin
         fill_in = fg;
         text_in = bg_color;
      end else begin
         fill_in = bg_color;
         text_in = fg;
      end

      // blank cell: no pen, no underline
      if (!attr.glyph) begin
         text_in  = '0;
         uline_in = 1'b0;
      end else begin
         uline_in = attr.underline || in_link;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         fill_ff  <= fill_in;
         text_ff  <= text_in;
         uline_ff <= uline_in;
      end
   end

   assign fill_color     = fill_ff;
   assign text_color     = text_ff;
   assign draw_underline = uline_ff;

endmodule

`default_nettype wire

// ===== rtl/core/terminal_cell_color_resolver_core.sv =====
// Terminal cell color resolver.
// Request channel (req_*): one text-cell attribute word per request; the color
// kinds ride in req_tuser, the components and cell flags in req_tdata.
// Response channel (rsp_*): one response per request with the fill color, the
// text color and the underline flag, all in rsp_tdata.
// Configuration (csr_*): a write lands at the clock edge where csr_we is
// high; registers 0..5 are default_fg, default_bg, dark_theme, selection_bg,
// link_fg and link_hover_fg. Other indexes are ignored. Write only while no
// request is in flight.
// Pipeline: the decode, palette lookup and compose register stages, in that order;
// rsp_tvalid is the valid bit of the compose stage.
// Throughput: one request per cycle while rsp_tready stays high; each stage holds a
// valid bit and moves on whenever the stage after it is empty or moving.
// Reset: all stages empty, registers at their documented defaults.
// Stall: when rsp_tready is low the last stage holds its request, earlier
// stages fill their bubbles, and req_tready drops once all three are full.
`default_nettype none

module terminal_cell_color_resolver_core (
   input  wire         clock,
   input  wire         reset,
   // request
   input  wire         req_tvalid,
   output logic        req_tready,
   // fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue, glyph_present,
   // style_flags, selected, link_state, zero pad
   input  wire  [55:0] req_tdata,
   // fg_kind, bg_kind
   input  wire  [3:0]  req_tuser,
   // response
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // fill_color, text_color, draw_underline, zero pad
   output logic [55:0] rsp_tdata,
   // configuration
   input  wire         csr_we,
   input  wire  [tcr_pkg::CsrAddrWidth-1:0] csr_addr,
   input  wire  [tcr_pkg::CsrDataWidth-1:0] csr_wdata
);

   tcr_pkg::rgb_type  default_fg_ff;
   tcr_pkg::rgb_type  default_fg_in;
   tcr_pkg::rgb_type  default_bg_ff;
   tcr_pkg::rgb_type  default_bg_in;
   logic              dark_theme_ff;
   logic              dark_theme_in;
   tcr_pkg::rgb_type  selection_bg_ff;
   tcr_pkg::rgb_type  selection_bg_in;
   tcr_pkg::rgb_type  link_fg_ff;
   tcr_pkg::rgb_type  link_fg_in;
   tcr_pkg::rgb_type  link_hover_fg_ff;
   tcr_pkg::rgb_type  link_hover_fg_in;

   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic              s2_valid_ff;
   logic              s2_valid_in;
   logic              s3_valid_ff;
   logic              s3_valid_in;
   logic              s1_ready;
   logic              s2_ready;
   logic              s3_ready;
   logic              s1_load;
   logic              s2_load;
   logic              s3_load;

   tcr_pkg::attr_type attr_req;
   tcr_pkg::attr_type attr_s1_ff;
   tcr_pkg::attr_type attr_s2_ff;

   tcr_pkg::dec_type  fg_dec;
   tcr_pkg::dec_type  bg_dec;
   tcr_pkg::rgb_type  fg_color;
   tcr_pkg::rgb_type  bg_color;
   tcr_pkg::rgb_type  fill_color;
   tcr_pkg::rgb_type  text_color;
   logic              draw_underline;

   // configuration registers
   always_comb begin
      default_fg_in    = default_fg_ff;
      default_bg_in    = default_bg_ff;
      dark_theme_in    = dark_theme_ff;
      selection_bg_in  = selection_bg_ff;
      link_fg_in       = link_fg_ff;
      link_hover_fg_in = link_hover_fg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            tcr_pkg::CSR_DEFAULT_FG:    default_fg_in    = csr_wdata;
            tcr_pkg::CSR_DEFAULT_BG:    default_bg_in    = csr_wdata;
            tcr_pkg::CSR_DARK_THEME:    dark_theme_in    = csr_wdata[0];
            tcr_pkg::CSR_SELECTION_BG:  selection_bg_in  = csr_wdata;
            tcr_pkg::CSR_LINK_FG:       link_fg_in       = csr_wdata;
            tcr_pkg::CSR_LINK_HOVER_FG: link_hover_fg_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_fg_ff    <= tcr_pkg::RESET_DEFAULT_FG;
         default_bg_ff    <= tcr_pkg::RESET_DEFAULT_BG;
         dark_theme_ff    <= 1'b1;
         selection_bg_ff  <= tcr_pkg::RESET_SELECTION_BG;
         link_fg_ff       <= tcr_pkg::RESET_LINK_FG;
         link_hover_fg_ff <= tcr_pkg::RESET_LINK_HOVER_FG;
      end else begin
         default_fg_ff    <= default_fg_in;
         default_bg_ff    <= default_bg_in;
         dark_theme_ff    <= dark_theme_in;
         selection_bg_ff  <= selection_bg_in;
         link_fg_ff       <= link_fg_in;
         link_hover_fg_ff <= link_hover_fg_in;
      end
   end

   // pipeline flow: a stage loads when it is empty or the next one takes its request
   always_comb begin
      s3_ready = !s3_valid_ff || rsp_tready;
      s2_ready = !s2_valid_ff || s3_ready;
      s1_ready = !s1_valid_ff || s2_ready;
      s1_load  = s1_ready && req_tvalid;
      s2_load  = s2_ready && s1_valid_ff;
      s3_load  = s3_ready && s2_valid_ff;
      s1_valid_in = s1_ready ? req_tvalid  : s1_valid_ff;
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
      s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_comb begin
      attr_req.glyph     = req_tdata[48];
      attr_req.underline = req_tdata[49];
      attr_req.inverse   = req_tdata[50];
      attr_req.selected  = req_tdata[51];
      attr_req.link      = tcr_pkg::link_type'(req_tdata[53:52]);
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         attr_s1_ff <= attr_req;
      end
      if (s2_load) begin
         attr_s2_ff <= attr_s1_ff;
      end
   end

   tcr_decode u_fg_decode (
      .clock  (clock),
      .enable (s1_load),
      .kind   (req_tuser[1:0]),
      .red    (req_tdata[7:0]),
      .green  (req_tdata[15:8]),
      .blue   (req_tdata[23:16]),
      .dec    (fg_dec)
   );

   tcr_decode u_bg_decode (
      .clock  (clock),
      .enable (s1_load),
      .kind   (req_tuser[3:2]),
      .red    (req_tdata[31:24]),
      .green  (req_tdata[39:32]),
      .blue   (req_tdata[47:40]),
      .dec    (bg_dec)
   );

   tcr_palette u_fg_palette (
      .clock         (clock),
      .enable        (s2_load),
      .dec           (fg_dec),
      .dark_theme    (dark_theme_ff),
      .default_color (default_fg_ff),
      .color         (fg_color)
   );

   tcr_palette u_bg_palette (
      .clock         (clock),
      .enable        (s2_load),
      .dec           (bg_dec),
      .dark_theme    (dark_theme_ff),
      .default_color (default_bg_ff),
      .color         (bg_color)
   );

   tcr_compose u_compose (
      .clock          (clock),
      .enable         (s3_load),
      .fg_color       (fg_color),
      .bg_color       (bg_color),
      .attr           (attr_s2_ff),
      .selection_bg   (selection_bg_ff),
      .link_fg        (link_fg_ff),
      .link_hover_fg  (link_hover_fg_ff),
      .fill_color     (fill_color),
      .text_color     (text_color),
      .draw_underline (draw_underline)
   );

   assign req_tready = s1_ready;
   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = {7'd0, draw_underline, text_color, fill_color};

`ifndef SYNTHESIS
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> s1_valid_ff)
      else $error("accepted request did not reach stage 1");

   a_s1_moves_into_empty_s2: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_valid_ff) |=> s2_valid_ff)
      else $error("stage 1 request did not advance into empty stage 2");

   a_s2_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s3_valid_ff && !rsp_tready) |=> s2_valid_ff)
      else $error("stalled stage 2 request was lost");

   a_ready_when_bubble: assert property (@(posedge clock) disable iff (reset)
      (!s1_valid_ff || !s2_valid_ff || !s3_valid_ff) |-> req_tready)
      else $error("request stalled while the pipeline has a bubble");
`endif

endmodule

`default_nettype wire

// ===== sim/terminal_cell_color_resolver_core_tb.sv =====
`timescale 1ns / 100ps

module terminal_cell_color_resolver_core_tb;
   import tcr_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned PIPE_DEPTH  = 3;

   localparam logic [1:0] STYLE_NONE      = 2'b00;
   localparam logic [1:0] STYLE_UNDERLINE = 2'b01;
   localparam logic [1:0] STYLE_INVERSE   = 2'b10;
   localparam logic [1:0] STYLE_BOTH      = 2'b11;
   // link code above hover; the block treats it as hover
   localparam logic [1:0] LINK_BEYOND     = 2'd3;

   localparam rgb_type DARK_COLORS [16] = '{
      24'h000000, 24'hCD0000, 24'h00CD00, 24'hCDCD00,
      24'h3B78FF, 24'hCD00CD, 24'h00CDCD, 24'hE5E5E5,
      24'h7F7F7F, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
      24'h5C5CFF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
   };

   localparam rgb_type LIGHT_COLORS [16] = '{
      24'h000000, 24'hCD0000, 24'h00A000, 24'hA07000,
      24'h0000EE, 24'hCD00CD, 24'h00A0A0, 24'h666666,
      24'h555555, 24'hFF0000, 24'h00CD00, 24'hCDCD00,
      24'h5C5CFF, 24'hFF00FF, 24'h00CDCD, 24'h444444
   };

   typedef struct {
      kind_type   fg_kind;
      logic [7:0] fg_r;
      logic [7:0] fg_g;
      logic [7:0] fg_b;
      kind_type   bg_kind;
      logic [7:0] bg_r;
      logic [7:0] bg_g;
      logic [7:0] bg_b;
      logic       glyph;
      logic [1:0] style;
      logic       sel;
      logic [1:0] link;
   } cell_word_type;

   typedef struct {
      rgb_type fill;
      rgb_type text;
      logic    uline;
   } cell_colors_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE
   } ready_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata  = '0;
   logic [3:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [CsrAddrWidth-1:0] csr_addr  = '0;
   logic [CsrDataWidth-1:0] csr_wdata = '0;

   // shadow of the color registers
   rgb_type dflt_fg   = RESET_DEFAULT_FG;
   rgb_type dflt_bg   = RESET_DEFAULT_BG;
   logic    dark_sel  = 1'b1;
   rgb_type sel_fill  = RESET_SELECTION_BG;
   rgb_type link_pen  = RESET_LINK_FG;
   rgb_type hover_pen = RESET_LINK_HOVER_FG;

   cell_word_type   pending_cells [$];
   cell_colors_type expected_colors [$];
   cell_word_type   cell_on_bus;
   cell_colors_type want_colors;
   cell_colors_type got_colors;

   int unsigned    fail_count  = 0;
   int unsigned    cycle_count = 0;
   int unsigned    burst_left  = 0;
   int unsigned    gap_left    = 0;
   int unsigned    ready_span  = 0;
   ready_mode_type ready_mode  = READY_ALWAYS;

   terminal_cell_color_resolver_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic logic [7:0] cube_step(input int unsigned c);
      return (c == 0) ? 8'd0 : 8'(55 + 40 * c);
   endfunction

   function automatic rgb_type palette_rgb(input logic [7:0] idx);
      int unsigned n;
      int unsigned gray;
      if (idx < 8'd16) begin
         return dark_sel ? DARK_COLORS[idx[3:0]] : LIGHT_COLORS[idx[3:0]];
      end
      if (idx <= 8'd231) begin
         n = idx - 16;
         return {cube_step(n / 36), cube_step((n / 6) % 6), cube_step(n % 6)};
      end
      gray = 8 + (idx - 232) * 10;
      return {3{8'(gray)}};
   endfunction

   function automatic rgb_type pick_color(input kind_type k, input logic [7:0] r,
                                          input logic [7:0] g, input logic [7:0] b,
                                          input rgb_type dflt);
      case (k)
         KIND_INDEX:  return palette_rgb(r);
         KIND_DIRECT: return {r, g, b};
         default:     return dflt;
      endcase
   endfunction

   function automatic cell_colors_type resolve_cell_colors(input cell_word_type c);
      rgb_type         pen;
      rgb_type         back;
      logic            inverse;
      cell_colors_type res;
      pen  = pick_color(c.fg_kind, c.fg_r, c.fg_g, c.fg_b, dflt_fg);
      back = pick_color(c.bg_kind, c.bg_r, c.bg_g, c.bg_b, dflt_bg);
      inverse = (c.style & STYLE_INVERSE) != 0;
      if (c.link == LINK_INSIDE) begin
         pen = link_pen;
      end else if (c.link != LINK_NONE) begin
         pen = hover_pen;
      end
      if (c.sel) begin
         res.fill = sel_fill;
         res.text = pen;
      end else if (c.glyph && inverse) begin
         res.fill = pen;
         res.text = back;
      end else begin
         res.fill = back;
         res.text = pen;
      end
      if (!c.glyph) begin
         res.text  = '0;
         res.uline = 1'b0;
      end else begin
         res.uline = ((c.style & STYLE_UNDERLINE) != 0) || (c.link != LINK_NONE);
      end
      return res;
   endfunction

   function automatic cell_word_type mk_cell(
      input kind_type fk, input logic [7:0] fr, input logic [7:0] fgr, input logic [7:0] fb,
      input kind_type bk, input logic [7:0] br, input logic [7:0] bgr, input logic [7:0] bb,
      input logic glyph, input logic [1:0] style, input logic sel, input logic [1:0] link);
      cell_word_type c;
      c.fg_kind = fk;  c.fg_r = fr;  c.fg_g = fgr;  c.fg_b = fb;
      c.bg_kind = bk;  c.bg_r = br;  c.bg_g = bgr;  c.bg_b = bb;
      c.glyph = glyph;  c.style = style;  c.sel = sel;  c.link = link;
      return c;
   endfunction

   // pick the theme, cube or gray region with equal odds, or else any index at all
   function automatic logic [7:0] random_index();
      case ($urandom_range(0, 3))
         0:       return 8'($urandom_range(0, 15));
         1:       return 8'($urandom_range(16, 231));
         2:       return 8'($urandom_range(232, 255));
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic cell_word_type random_cell();
      cell_word_type c;
      int unsigned   pick;
      c.fg_kind = kind_type'(2'($urandom_range(0, 3)));
      c.fg_r    = random_index();
      c.fg_g    = 8'($urandom);
      c.fg_b    = 8'($urandom);
      c.bg_kind = kind_type'(2'($urandom_range(0, 3)));
      c.bg_r    = random_index();
      c.bg_g    = 8'($urandom);
      c.bg_b    = 8'($urandom);
      c.glyph   = ($urandom_range(0, 4) != 0);
      c.style   = 2'($urandom);
      c.sel     = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 7);
      if (pick < 4) begin
         c.link = LINK_NONE;
      end else if (pick < 6) begin
         c.link = LINK_INSIDE;
      end else if (pick == 6) begin
         c.link = LINK_HOVER;
      end else begin
         c.link = LINK_BEYOND;
      end
      return c;
   endfunction

   // append one request to the end of the pending queue
   task automatic queue_cell(input cell_word_type c);
      pending_cells.insert(pending_cells.size(), c);
   endtask

   task automatic load_directed();
      queue_cell(mk_cell(KIND_DEFAULT, 8'h00, 8'h00, 8'h00,
         KIND_DEFAULT, 8'h00, 8'h00, 8'h00, 1'b1, STYLE_NONE, 1'b0, LINK_NONE));
      queue_cell(mk_cell(KIND_DEFAULT_ALT, 8'hFF, 8'hFF, 8'hFF,
         KIND_DEFAULT_ALT, 8'hFF, 8'hFF, 8'hFF, 1'b1, STYLE_NONE, 1'b0, LINK_NONE));
      queue_cell(mk_cell(KIND_INDEX, 8'd0, 8'hFF, 8'hFF,
         KIND_INDEX, 8'd15, 8'h00, 8'h00, 1'b1, STYLE_NONE, 1'b0, LINK_NONE));
      queue_cell(mk_cell(KIND_INDEX, 8'd15, 8'h00, 8'h00,
         KIND_INDEX, 8'd0, 8'hFF, 8'hFF, 1'b1, STYLE_NONE, 1'b0, LINK_NONE));
      queue_cell(mk_cell(KIND_INDEX, 8'd16, 8'h00, 8'h00,
         KIND_INDEX, 8'd231, 8'h00, 8'h00, 1'b1, STYLE_NONE, 1'b0, LINK_NONE));
      queue_cell(mk_cell(KIND_INDEX, 8'd231, 8'h00, 8'h00,
         KIND_INDEX, 8'd16, 8'h00, 8'h00, 1'b1, STYLE_NONE, 1'b0, LINK_NONE));
      queue_cell(mk_cell(KIND_INDEX, 8'd232, 8'h00, 8'h00,
         KIND_INDEX, 8'd255, 8'h00, 8'h00, 1'b1, STYLE_NONE, 1'b0, LINK_NONE));
      queue_cell(mk_cell(KIND_INDEX, 8'd255, 8'h00, 8'h00,
         KIND_INDEX, 8'd232, 8'h00, 8'h00, 1'b1, STYLE_NONE, 1'b0, LINK_NONE));
      queue_cell(mk_cell(KIND_INDEX, 8'd7, 8'h00, 8'h00,
         KIND_INDEX, 8'd4, 8'h00, 8'h00, 1'b1, STYLE_NONE, 1'b0, LINK_NONE));
      queue_cell(mk_cell(KIND_DIRECT, 8'h00, 8'h00, 8'h00,
         KIND_DIRECT, 8'hFF, 8'hFF, 8'hFF, 1'b1, STYLE_NONE, 1'b0, LINK_NONE));
      queue_cell(mk_cell(KIND_DIRECT, 8'hFF, 8'hFF, 8'hFF,
         KIND_DIRECT, 8'h00, 8'h00, 8'h00, 1'b1, STYLE_NONE, 1'b0, LINK_NONE));
      queue_cell(mk_cell(KIND_DIRECT, 8'h12, 8'h34, 8'h56,
         KIND_DIRECT, 8'hA5, 8'h5A, 8'hC3, 1'b1, STYLE_UNDERLINE, 1'b0, LINK_NONE));
      // inverse swaps only on an unselected cell with a glyph
      queue_cell(mk_cell(KIND_DIRECT, 8'h12, 8'h34, 8'h56,
         KIND_DIRECT, 8'hA5, 8'h5A, 8'hC3, 1'b1, STYLE_INVERSE, 1'b0, LINK_NONE));
      queue_cell(mk_cell(KIND_DIRECT, 8'h12, 8'h34, 8'h56,
         KIND_DIRECT, 8'hA5, 8'h5A, 8'hC3, 1'b1, STYLE_INVERSE, 1'b1, LINK_NONE));
      queue_cell(mk_cell(KIND_INDEX, 8'd100, 8'h00, 8'h00,
         KIND_INDEX, 8'd200, 8'h00, 8'h00, 1'b1, STYLE_NONE, 1'b1, LINK_NONE));
      // blank cell: no swap, no link, text forced to zero
      queue_cell(mk_cell(KIND_DIRECT, 8'h12, 8'h34, 8'h56,
         KIND_DIRECT, 8'hA5, 8'h5A, 8'hC3, 1'b0, STYLE_BOTH, 1'b0, LINK_HOVER));
      queue_cell(mk_cell(KIND_INDEX, 8'd9, 8'h00, 8'h00,
         KIND_INDEX, 8'd3, 8'h00, 8'h00, 1'b0, STYLE_NONE, 1'b1, LINK_INSIDE));
      queue_cell(mk_cell(KIND_INDEX, 8'd9, 8'h00, 8'h00,
         KIND_INDEX, 8'd3, 8'h00, 8'h00, 1'b1, STYLE_NONE, 1'b0, LINK_INSIDE));
      queue_cell(mk_cell(KIND_INDEX, 8'd9, 8'h00, 8'h00,
         KIND_INDEX, 8'd3, 8'h00, 8'h00, 1'b1, STYLE_NONE, 1'b0, LINK_HOVER));
      queue_cell(mk_cell(KIND_DEFAULT, 8'h00, 8'h00, 8'h00,
         KIND_DEFAULT, 8'h00, 8'h00, 8'h00, 1'b1, STYLE_INVERSE, 1'b0, LINK_BEYOND));
      queue_cell(mk_cell(KIND_DIRECT, 8'h80, 8'h40, 8'h20,
         KIND_INDEX, 8'd244, 8'h00, 8'h00, 1'b1, STYLE_INVERSE, 1'b1, LINK_INSIDE));
      queue_cell(mk_cell(KIND_DIRECT, 8'h80, 8'h40, 8'h20,
         KIND_DIRECT, 8'h01, 8'h02, 8'h04, 1'b1, STYLE_BOTH, 1'b0, LINK_NONE));
   endtask

   task automatic load_random(input int unsigned count);
      repeat (count) queue_cell(random_cell());
   endtask

   task automatic write_csr(input csr_index_type idx, input rgb_type value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_DEFAULT_FG:    dflt_fg   = value;
         CSR_DEFAULT_BG:    dflt_bg   = value;
         CSR_DARK_THEME:    dark_sel  = value[0];
         CSR_SELECTION_BG:  sel_fill  = value;
         CSR_LINK_FG:       link_pen  = value;
         CSR_LINK_HOVER_FG: hover_pen = value;
         default: ;
      endcase
   endtask

   task automatic write_colors(input rgb_type fg, input rgb_type bg, input rgb_type theme,
                               input rgb_type sel, input rgb_type lnk, input rgb_type hov);
      write_csr(CSR_DEFAULT_FG, fg);
      write_csr(CSR_DEFAULT_BG, bg);
      write_csr(CSR_DARK_THEME, theme);
      write_csr(CSR_SELECTION_BG, sel);
      write_csr(CSR_LINK_FG, lnk);
      write_csr(CSR_LINK_HOVER_FG, hov);
   endtask

   // hold until every request is answered, then let the pipeline settle
   task automatic drain();
      do begin
         @(posedge clock);
      end while (pending_cells.size() != 0 || req_tvalid || expected_colors.size() != 0);
      repeat (PIPE_DEPTH + 2) @(posedge clock);
   endtask

   // request driver: bursts of random length with random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_colors.insert(expected_colors.size(), resolve_cell_colors(cell_on_bus));
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_cells.size() != 0) begin
               cell_on_bus = pending_cells.pop_front();
               req_tdata  <= {2'b00, cell_on_bus.link, cell_on_bus.sel, cell_on_bus.style,
                              cell_on_bus.glyph, cell_on_bus.bg_b, cell_on_bus.bg_g,
                              cell_on_bus.bg_r, cell_on_bus.fg_b, cell_on_bus.fg_g,
                              cell_on_bus.fg_r};
               req_tuser  <= {cell_on_bus.bg_kind, cell_on_bus.fg_kind};
               req_tvalid <= 1'b1;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response ready: switch between free flow, coin flips and sparse acceptance
   always @(posedge clock) begin
      if (ready_span == 0) begin
         ready_span = $urandom_range(20, 200);
         ready_mode = ready_mode_type'(2'($urandom_range(0, 2)));
      end else begin
         ready_span--;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         default:      rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_colors.fill  = rsp_tdata[23:0];
         got_colors.text  = rsp_tdata[47:24];
         got_colors.uline = rsp_tdata[48];
         if (expected_colors.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("unexpected response fill=%h text=%h uline=%b",
                        got_colors.fill, got_colors.text, got_colors.uline);
            end
         end else begin
            want_colors = expected_colors.pop_front();
            if (got_colors.fill !== want_colors.fill || got_colors.text !== want_colors.text
                || got_colors.uline !== want_colors.uline) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("mismatch: expected fill=%h text=%h uline=%b, got fill=%h text=%h uline=%b",
                           want_colors.fill, want_colors.text, want_colors.uline,
                           got_colors.fill, got_colors.text, got_colors.uline);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("terminal_cell_color_resolver_core regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset colors
      load_directed();
      drain();

      // one extreme; the theme value keeps upper bits set to exercise masking
      write_colors(24'h000000, 24'hFFFFFF, 24'hFFFFFE, 24'h000000, 24'hFFFFFF, 24'h000000);
      load_directed();
      load_random(60);
      drain();

      // the opposite extreme
      write_colors(24'hFFFFFF, 24'h000000, 24'h000001, 24'hFFFFFF, 24'h000000, 24'hFFFFFF);
      load_directed();
      load_random(60);
      drain();

      repeat (7) begin
         write_colors(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                      24'($urandom), 24'($urandom));
         load_random(100);
         drain();
      end

      if (fail_count == 0 && expected_colors.size() == 0) begin
         $display("terminal_cell_color_resolver_core regression: pass");
      end else begin
         $display("terminal_cell_color_resolver_core regression: fail");
      end
      $finish;
   end

endmodule

// ===== terminal_cell_color_resolver_core.f =====
rtl/core/tcr_pkg.sv
rtl/core/tcr_decode.sv
rtl/core/tcr_palette.sv
rtl/core/tcr_compose.sv
rtl/core/terminal_cell_color_resolver_core.sv
sim/terminal_cell_color_resolver_core_tb.sv
